// ===== hdl/sstf_pkg.sv =====
// Shared types, constants and the control word of the SSTF disk scheduler.
package sstf_pkg;

  // Cylinder range and reset head position.
  localparam int unsigned CYL_W = 10;
  localparam int unsigned SUM_W = 16;
  localparam logic [CYL_W:0] CYL_COUNT = 11'd1024;
  localparam logic [CYL_W-1:0] CYL_MAX = CYL_W'(CYL_COUNT - 11'd1);
  localparam logic [CYL_W-1:0] START_RESET = 10'd30;
  localparam logic [SUM_W-1:0] SUM_MAX = 16'hFFFF;

  // One incoming request.
  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             last_request;
  } req_t;

  // One served request.
  typedef struct packed {
    logic [CYL_W-1:0] served_cylinder;
    logic [CYL_W-1:0] seek_distance;
    logic [SUM_W-1:0] total_movement;
    logic             overflow;
    logic             last_result;
  } res_t;

  // Datapath controls carried by each microcode word.
  typedef struct packed {
    logic idle;
    logic load_batch;
    logic best_clr;
    logic idx_clr;
    logic scan_rd;
    logic serve;
    logic clr_queue;
  } ctl_t;

  // Datapath status seen by the sequencer's jump logic.
  typedef struct packed {
    logic acc_last;
    logic cnt_zero;
    logic scan_end;
    logic more;
  } stat_t;

  // Microcode step addresses.
  typedef logic [2:0] step_t;
  localparam step_t S_WAIT  = 3'd0;
  localparam step_t S_INIT  = 3'd1;
  localparam step_t S_SCAN  = 3'd2;
  localparam step_t S_DRAIN = 3'd3;
  localparam step_t S_SERVE = 3'd4;
  localparam step_t S_CLEAR = 3'd5;

  // Jump conditions.
  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_ACC_LAST,
    J_CNT_ZERO,
    J_SCAN_END,
    J_MORE
  } jcond_t;

  // Saturate a cylinder number to the last cylinder of the disk.
  function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] v);
    logic [CYL_W-1:0] r;
    r = v;
    if ({1'b0, v} >= CYL_COUNT) begin
      r = CYL_MAX;
    end
    return r;
  endfunction

endpackage

// ===== hdl/sstf_seq.sv =====
// Microcode store and step counter of the SSTF disk scheduler.
module sstf_seq (
  input  logic           clk,
  input  logic           rst,
  input  sstf_pkg::stat_t stat,
  output sstf_pkg::ctl_t  ctl
);
  import sstf_pkg::*;

  step_t  step;
  step_t  step_next;
  jcond_t jc;
  logic   hold;
  step_t  target;
  logic   take;

  // Program store: one control word per step.
  always_comb begin
    ctl    = '0;
    jc     = J_NEVER;
    hold   = 1'b0;
    target = S_WAIT;
    case (step)
      S_WAIT: begin
        ctl.idle = 1'b1;
        jc       = J_ACC_LAST;
        hold     = 1'b1;
        target   = S_INIT;
      end
      S_INIT: begin
        ctl.load_batch = 1'b1;
        ctl.best_clr   = 1'b1;
        ctl.idx_clr    = 1'b1;
        jc             = J_CNT_ZERO;
        target         = S_CLEAR;
      end
      S_SCAN: begin
        ctl.scan_rd = 1'b1;
        jc          = J_SCAN_END;
        hold        = 1'b1;
        target      = S_DRAIN;
      end
      S_DRAIN: begin
        jc = J_NEVER;
      end
      S_SERVE: begin
        ctl.serve    = 1'b1;
        ctl.best_clr = 1'b1;
        ctl.idx_clr  = 1'b1;
        jc           = J_MORE;
        target       = S_SCAN;
      end
      S_CLEAR: begin
        ctl.clr_queue = 1'b1;
        jc            = J_ALWAYS;
        target        = S_WAIT;
      end
      default: begin
        jc     = J_ALWAYS;
        target = S_WAIT;
      end
    endcase
  end

  // Jump condition select.
  always_comb begin
    case (jc)
      J_ALWAYS:   take = 1'b1;
      J_ACC_LAST: take = stat.acc_last;
      J_CNT_ZERO: take = stat.cnt_zero;
      J_SCAN_END: take = stat.scan_end;
      J_MORE:     take = stat.more;
      default:    take = 1'b0;
    endcase
  end

  // Next step: jump, hold or fall through.
  always_comb begin
    if (take) begin
      step_next = target;
    end else if (hold) begin
      step_next = step;
    end else begin
      step_next = step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hdl/sstf_dpath.sv =====
// Request store, nearest-request scan and result register of the SSTF scheduler.
module sstf_dpath #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sstf_pkg::ctl_t                ctl,
  output sstf_pkg::stat_t               stat,
  input  logic                          start,
  input  sstf_pkg::req_t                request,
  input  logic                          cfg_write,
  input  logic [sstf_pkg::CYL_W-1:0]    cfg_data,
  output logic                          result_valid,
  output sstf_pkg::res_t                result
);
  import sstf_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CYL_W-1:0]       mem [QUEUE_DEPTH];
  logic [CYL_W-1:0]       rd_cyl;
  logic [QUEUE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       remaining;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       rd_idx;
  logic                   rd_pend;
  logic                   drop;
  logic [CYL_W-1:0]       start_pos;
  logic [CYL_W-1:0]       head;
  logic [SUM_W-1:0]       sum;
  logic                   best_found;
  logic [IDX_W-1:0]       best_idx;
  logic [CYL_W-1:0]       best_cyl;
  logic [CYL_W-1:0]       best_dist;

  logic                   accept;
  logic                   has_room;
  logic [CYL_W-1:0]       delta;
  logic                   better;
  logic [SUM_W:0]         sum_wide;
  logic [SUM_W-1:0]       sum_next;

  assign accept   = ctl.idle & start;
  assign has_room = count < CNT_W'(QUEUE_DEPTH);

  // Status for the sequencer.
  assign stat.acc_last = accept & request.last_request;
  assign stat.cnt_zero = count == '0;
  assign stat.scan_end = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign stat.more     = remaining != CNT_W'(1);

  // Distance from the head to the entry just read, and the nearest-so-far test.
  assign delta  = (rd_cyl > head) ? (rd_cyl - head) : (head - rd_cyl);
  assign better = rd_pend & valid[rd_idx] & (~best_found | (delta < best_dist));

  // Saturating running total.
  assign sum_wide = {1'b0, sum} + (SUM_W + 1)'(best_dist);
  assign sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  // Request store: written on accept while there is room, read one entry a cycle during the scan.
  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      mem[count[IDX_W-1:0]] <= clamp_cyl(request.cylinder);
    end
    rd_cyl <= mem[idx];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos    <= START_RESET;
      count        <= '0;
      valid        <= '0;
      drop         <= 1'b0;
      rd_pend      <= 1'b0;
      best_found   <= 1'b0;
      remaining    <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        start_pos <= cfg_data;
      end
      // Queue a new request, or note that it was dropped.
      if (accept) begin
        if (has_room) begin
          valid[count[IDX_W-1:0]] <= 1'b1;
          count                   <= count + CNT_W'(1);
        end else begin
          drop <= 1'b1;
        end
      end
      if (ctl.load_batch) begin
        remaining <= count;
      end
      // Scan address and read pipeline.
      if (ctl.idx_clr) begin
        idx <= '0;
      end else if (ctl.scan_rd) begin
        idx <= idx + IDX_W'(1);
      end
      rd_pend <= ctl.scan_rd;
      if (ctl.best_clr) begin
        best_found <= 1'b0;
      end else if (better) begin
        best_found <= 1'b1;
      end
      // Serve the nearest request.
      result_valid <= ctl.serve;
      if (ctl.serve) begin
        valid[best_idx] <= 1'b0;
        remaining       <= remaining - CNT_W'(1);
      end
      if (ctl.clr_queue) begin
        count <= '0;
        valid <= '0;
        drop  <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (better) begin
      best_idx  <= rd_idx;
      best_cyl  <= rd_cyl;
      best_dist <= delta;
    end
    if (ctl.load_batch) begin
      head <= clamp_cyl(start_pos);
      sum  <= '0;
    end else if (ctl.serve) begin
      head <= best_cyl;
      sum  <= sum_next;
    end
    if (ctl.serve) begin
      result.served_cylinder <= best_cyl;
      result.seek_distance   <= best_dist;
      result.total_movement  <= sum_next;
      result.overflow        <= drop;
      result.last_result     <= remaining == CNT_W'(1);
    end
  end

endmodule

// ===== hdl/sstf_disk_scheduler_core.sv =====
// Top level of the shortest-seek-time-first disk scheduler.
//
//   channel   ports                          direction  handshake
//   request   start, busy, request           in         taken when start & !busy
//   result    result_valid, result           out        one cycle strobe, no stall
//   config    cfg_write, cfg_data            in         written when cfg_write
//
// Requests are queued one a cycle while busy is low; the last request of a
// batch starts service and busy stays high until the batch has been served.
// For each served request the single read port of the request store is
// swept once over the queued requests. Reset is synchronous and leaves the
// queue empty with the head start position at cylinder 30.
// Results cannot be held off; each is shown for exactly one cycle.
module sstf_disk_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  sstf_pkg::req_t                request,
  input  logic                          cfg_write,
  input  logic [sstf_pkg::CYL_W-1:0]    cfg_data,
  output logic                          result_valid,
  output sstf_pkg::res_t                result
);
  import sstf_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // Microcode sequencer.
  sstf_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // Datapath.
  sstf_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .start        (start),
    .request      (request),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  assign busy = ~ctl.idle;

endmodule
